@@ hdl/sule_pkg.sv @@
// Package for the sorted unique list engine.
// Holds opcodes, status codes, cell commands and defaults. No dependencies.
`default_nettype none
package sule_pkg;

   localparam int DEPTH_DEFAULT     = 32;
   localparam int KEY_WIDTH_DEFAULT = 32;
   localparam int POS_WIDTH         = 5;
   localparam int CAP_WIDTH         = 6;
   localparam int OP_WIDTH          = 2;
   localparam int STATUS_WIDTH      = 3;

   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 6'd32;

   localparam logic [OP_WIDTH-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_SEARCH = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_SHOW   = 2'd3;

   localparam logic [STATUS_WIDTH-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_DUP      = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_REMOVED  = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_ABSENT   = 3'd4;
   localparam logic [STATUS_WIDTH-1:0] ST_FOUND    = 3'd5;
   localparam logic [STATUS_WIDTH-1:0] ST_ENTRY    = 3'd6;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY    = 3'd7;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INS,
      CMD_DEL,
      CMD_ROT
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    valid;
      logic    tail;
   } cell_ctl_type;

endpackage
`default_nettype wire

@@ hdl/sule_cell.sv @@
// One cell of the list chain: holds one entry, compares it to the request key
// and takes its own, a neighbor's, the head's or the key. Depends on sule_pkg.
`default_nettype none
module sule_cell #(
   parameter int KEY_WIDTH = sule_pkg::KEY_WIDTH_DEFAULT
) (
   input  wire                        clock,
   input  wire sule_pkg::cell_ctl_type ctl,
   input  wire logic [KEY_WIDTH-1:0]  key,
   input  wire logic                  prev_lt,
   input  wire logic [KEY_WIDTH-1:0]  prev_entry,
   input  wire logic [KEY_WIDTH-1:0]  next_entry,
   input  wire logic [KEY_WIDTH-1:0]  head_entry,
   output logic                       lt,
   output logic                       eq,
   output logic [KEY_WIDTH-1:0]       entry
);
   import sule_pkg::*;

   logic [KEY_WIDTH-1:0] entry_ff;
   logic [KEY_WIDTH-1:0] entry_in;

   assign entry = entry_ff;
   assign lt    = ctl.valid && ($signed(entry_ff) < $signed(key));
   assign eq    = ctl.valid && (entry_ff == key);

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.cmd)
         CMD_HOLD: entry_in = entry_ff;
         CMD_INS: begin
            if (!prev_lt) begin
               entry_in = prev_entry;
            end else if (!lt) begin
               entry_in = key;
            end
         end
         CMD_DEL: begin
            if (!lt) begin
               entry_in = next_entry;
            end
         end
         CMD_ROT: entry_in = ctl.tail ? head_entry : next_entry;
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

@@ hdl/sorted_unique_list_engine_unit.sv @@
// Top level of the sorted unique list engine: request/result handshake,
// sequencer and the chain of sule_cell entries. Depends on sule_pkg, sule_cell.
//
//  channel | ports                          | payload
//  req     | req_tvalid/tready/tdata/tuser  | tdata: key; tuser: opcode
//  rsp     | rsp_tvalid/tready/tdata/tuser  | tdata: position, item; tuser: status;
//          |   rsp_tlast                    |   tlast: last
//  csr     | csr_wen/csr_wdata              | capacity
//
// Insert, remove and search: the request is accepted in S_IDLE, then in S_EXEC
// all cells compare and shift in parallel. Show emits one result per entry, or
// one empty result, as the chain rotates by one place per emitted result.
// Reset empties the list and sets capacity to 32. A stalled result holds the
// sequencer; no request is accepted until the current one is finished.
`default_nettype none
module sorted_unique_list_engine_unit #(
   parameter int DEPTH     = sule_pkg::DEPTH_DEFAULT,
   parameter int KEY_WIDTH = sule_pkg::KEY_WIDTH_DEFAULT,
   localparam int REQ_W    = ((KEY_WIDTH + 7) / 8) * 8,
   localparam int RSP_W    = ((sule_pkg::POS_WIDTH + KEY_WIDTH + 7) / 8) * 8
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   input  wire logic [REQ_W-1:0]                  req_tdata,  // key
   input  wire logic [sule_pkg::OP_WIDTH-1:0]     req_tuser,  // opcode
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [RSP_W-1:0]                       rsp_tdata,  // position, item, zero pad
   output logic [sule_pkg::STATUS_WIDTH-1:0]      rsp_tuser,  // status
   output logic                                   rsp_tlast,
   input  wire                                    csr_wen,
   input  wire logic [sule_pkg::CAP_WIDTH-1:0]    csr_wdata
);
   import sule_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_WIDTH) ? CNT_W : CAP_WIDTH;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SHOW
   } state_type;

   state_type                 state_ff;
   logic [OP_WIDTH-1:0]       op_ff;
   logic [KEY_WIDTH-1:0]      key_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          idx_ff;
   logic [CAP_WIDTH-1:0]      capacity_ff;
   logic                      rsp_valid_ff;
   logic [STATUS_WIDTH-1:0]   rsp_status_ff;
   logic [POS_WIDTH-1:0]      rsp_pos_ff;
   logic [KEY_WIDTH-1:0]      rsp_item_ff;
   logic                      rsp_last_ff;

   cell_ctl_type              ctl [DEPTH];
   logic [KEY_WIDTH-1:0]      entry_w [DEPTH];
   logic [DEPTH:0]            lt_w;
   logic [DEPTH-1:0]          eq_w;
   cmd_type                   cmd;
   logic [CNT_W-1:0]          pos;
   logic                      found;
   logic                      full;
   logic                      out_free;
   logic                      rsp_load;
   logic [CMP_W-1:0]          eff_cap;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_W'({rsp_item_ff, rsp_pos_ff});
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = ((state_ff == S_EXEC) || (state_ff == S_SHOW)) && out_free;

   assign eff_cap = (CMP_W'(capacity_ff) < CMP_W'(DEPTH)) ? CMP_W'(capacity_ff)
                                                           : CMP_W'(DEPTH);
   assign full    = CMP_W'(count_ff) >= eff_cap;
   assign found   = |eq_w;
   assign lt_w[DEPTH] = 1'b0;

   // Entries below the count are sorted, so lt_w is a thermometer code.
   always_comb begin
      pos = '0;
      for (int i = 0; i <= DEPTH; i++) begin
         if (((i == 0) || lt_w[(i == 0) ? 0 : i - 1]) && !lt_w[i]) begin
            pos = pos | CNT_W'(i);
         end
      end
   end

   always_comb begin
      cmd = CMD_HOLD;
      unique case (state_ff)
         S_IDLE: cmd = CMD_HOLD;
         S_EXEC: begin
            if (out_free) begin
               if (op_ff == OP_INSERT && !found && !full) begin
                  cmd = CMD_INS;
               end else if (op_ff == OP_REMOVE && found) begin
                  cmd = CMD_DEL;
               end
            end
         end
         S_SHOW: begin
            if (out_free && count_ff != '0) begin
               cmd = CMD_ROT;
            end
         end
         default: cmd = CMD_HOLD;
      endcase
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      assign ctl[g] = {cmd, CNT_W'(g) < count_ff, CNT_W'(g + 1) == count_ff};

      sule_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl[g]),
         .key        (key_ff),
         .prev_lt    ((g == 0) ? 1'b1 : lt_w[(g == 0) ? 0 : g - 1]),
         .prev_entry (entry_w[(g == 0) ? 0 : g - 1]),
         .next_entry (entry_w[(g == DEPTH - 1) ? g : g + 1]),
         .head_entry (entry_w[0]),
         .lt         (lt_w[g]),
         .eq         (eq_w[g]),
         .entry      (entry_w[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            capacity_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff    <= req_tuser;
                  key_ff   <= req_tdata[KEY_WIDTH-1:0];
                  idx_ff   <= '0;
                  state_ff <= (req_tuser == OP_SHOW) ? S_SHOW : S_EXEC;
               end
            end
            S_EXEC: begin
               if (out_free) begin
                  rsp_item_ff  <= key_ff;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= S_IDLE;
                  priority if (op_ff == OP_INSERT) begin
                     if (found) begin
                        rsp_status_ff <= ST_DUP;
                        rsp_pos_ff    <= POS_WIDTH'(pos);
                     end else if (full) begin
                        rsp_status_ff <= ST_FULL;
                        rsp_pos_ff    <= '0;
                     end else begin
                        rsp_status_ff <= ST_INSERTED;
                        rsp_pos_ff    <= POS_WIDTH'(pos);
                        count_ff      <= count_ff + CNT_W'(1);
                     end
                  end else if (!found) begin
                     rsp_status_ff <= ST_ABSENT;
                     rsp_pos_ff    <= '0;
                  end else if (op_ff == OP_REMOVE) begin
                     rsp_status_ff <= ST_REMOVED;
                     rsp_pos_ff    <= POS_WIDTH'(pos);
                     count_ff      <= count_ff - CNT_W'(1);
                  end else begin
                     rsp_status_ff <= ST_FOUND;
                     rsp_pos_ff    <= POS_WIDTH'(pos);
                  end
               end
            end
            S_SHOW: begin
               if (out_free) begin
                  if (count_ff == '0) begin
                     rsp_status_ff <= ST_EMPTY;
                     rsp_pos_ff    <= '0;
                     rsp_item_ff   <= '0;
                     rsp_last_ff   <= 1'b1;
                     state_ff      <= S_IDLE;
                  end else begin
                     rsp_status_ff <= ST_ENTRY;
                     rsp_pos_ff    <= POS_WIDTH'(idx_ff);
                     rsp_item_ff   <= entry_w[0];
                     rsp_last_ff   <= (idx_ff + CNT_W'(1)) == count_ff;
                     idx_ff        <= idx_ff + CNT_W'(1);
                     if ((idx_ff + CNT_W'(1)) == count_ff) begin
                        state_ff <= S_IDLE;
                     end
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for sorted_unique_list_engine_unit.
// Keeps its own sorted key list, predicts every response and compares it on
// the response stream. Depends on sule_pkg and the RTL of the engine.
module testbench;
   import sule_pkg::*;

   localparam int KEY_W      = 32;
   localparam int IDLE_LIMIT = 2000;

   class list_scoreboard;
      typedef struct {
         logic [STATUS_WIDTH-1:0] status;
         logic [POS_WIDTH-1:0]    position;
         logic [KEY_W-1:0]        item;
         logic                    last;
      } list_result_type;

      logic signed [KEY_W-1:0] sorted_keys[$];
      list_result_type         expected_results[$];
      int                      cap_limit = 32;
      int                      errors = 0;

      function void set_capacity(logic [CAP_WIDTH-1:0] value);
         cap_limit = (value < 32) ? int'(value) : 32;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function int entries();
         return sorted_keys.size();
      endfunction

      function logic [KEY_W-1:0] random_entry();
         return sorted_keys[$urandom_range(sorted_keys.size() - 1)];
      endfunction

      function int locate(logic signed [KEY_W-1:0] key);
         for (int i = 0; i < sorted_keys.size(); i++)
            if (sorted_keys[i] == key) return i;
         return -1;
      endfunction

      function void push(logic [STATUS_WIDTH-1:0] status, int pos,
                         logic [KEY_W-1:0] item, logic last);
         list_result_type r;
         r.status   = status;
         r.position = pos[POS_WIDTH-1:0];
         r.item     = item;
         r.last     = last;
         expected_results.push_back(r);
      endfunction

      function void note_request(logic [OP_WIDTH-1:0] op, logic signed [KEY_W-1:0] key);
         int hit;
         int slot;
         hit = locate(key);
         case (op)
            OP_INSERT: begin
               if (hit >= 0) begin
                  push(ST_DUP, hit, key, 1'b1);
               end else if (sorted_keys.size() >= cap_limit) begin
                  push(ST_FULL, 0, key, 1'b1);
               end else begin
                  slot = 0;
                  while (slot < sorted_keys.size() && sorted_keys[slot] < key) slot++;
                  sorted_keys.insert(slot, key);
                  push(ST_INSERTED, slot, key, 1'b1);
               end
            end
            OP_REMOVE: begin
               if (hit < 0) begin
                  push(ST_ABSENT, 0, key, 1'b1);
               end else begin
                  sorted_keys.delete(hit);
                  push(ST_REMOVED, hit, key, 1'b1);
               end
            end
            OP_SEARCH: begin
               if (hit < 0) push(ST_ABSENT, 0, key, 1'b1);
               else push(ST_FOUND, hit, key, 1'b1);
            end
            default: begin
               if (sorted_keys.size() == 0) begin
                  push(ST_EMPTY, 0, '0, 1'b1);
               end else begin
                  for (int i = 0; i < sorted_keys.size(); i++)
                     push(ST_ENTRY, i, sorted_keys[i], i == sorted_keys.size() - 1);
               end
            end
         endcase
      endfunction

      function void check_result(logic [STATUS_WIDTH-1:0] status,
                                 logic [POS_WIDTH-1:0] position,
                                 logic [KEY_W-1:0] item, logic last);
         list_result_type want;
         if (expected_results.size() == 0) begin
            $error("unexpected response: status %0d position %0d item %h last %0d",
                   status, position, item, last);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
         end
         if (position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, position);
            errors++;
         end
         if (item !== want.item) begin
            $error("item: expected %h, actual %h", want.item, item);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [KEY_W-1:0]        req_tdata = '0;  // key
   logic [OP_WIDTH-1:0]     req_tuser = OP_INSERT;  // opcode
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [39:0]             rsp_tdata;  // position, item, zero pad
   logic [STATUS_WIDTH-1:0] rsp_tuser;  // status
   logic                    rsp_tlast;
   logic                    csr_wen = 1'b0;
   logic [CAP_WIDTH-1:0]    csr_wdata = '0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int stuck_cycles = 0;

   list_scoreboard sb = new;

   sorted_unique_list_engine_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tuser, rsp_tdata[POS_WIDTH-1:0],
                            rsp_tdata[POS_WIDTH+KEY_W-1:POS_WIDTH], rsp_tlast);
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles == IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_request(input logic [OP_WIDTH-1:0] op, input logic [KEY_W-1:0] key);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_WIDTH-1:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.set_capacity(value);
      @(posedge clock);
   endtask

   // keys cluster on a few values so that duplicates and hits are common
   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] k;
      int r;
      r = $urandom_range(99);
      if (r < 35 && sb.entries() != 0) return sb.random_entry();
      if (r < 60) begin
         case ($urandom_range(5))
            0: k = 32'h8000_0000;
            1: k = 32'h7FFF_FFFF;
            2: k = 32'h0000_0000;
            3: k = 32'hFFFF_FFFF;
            default: begin
               k = $urandom_range(15) << 16;
               if ($urandom_range(1) != 0) k = -k;
            end
         endcase
         return k;
      end
      return $urandom;
   endfunction

   function automatic logic [OP_WIDTH-1:0] pick_op(input int insert_pct);
      int r;
      if ($urandom_range(99) < insert_pct) return OP_INSERT;
      r = $urandom_range(9);
      if (r < 4) return OP_REMOVE;
      if (r < 8) return OP_SEARCH;
      return OP_SHOW;
   endfunction

   task automatic run_phase(input logic [CAP_WIDTH-1:0] cap, input int send_pct,
                            input int stall, input int count, input int insert_pct);
      wait_idle();
      write_capacity(cap);
      send_idle_pct = send_pct;
      stall_pct     = stall;
      repeat (count) send_request(pick_op(insert_pct), pick_key());
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list
      send_request(OP_SHOW,   32'h0000_0000);
      send_request(OP_SEARCH, 32'h0000_0000);
      send_request(OP_REMOVE, 32'h0000_0005);
      // key extremes, sorted placement, duplicate
      send_request(OP_INSERT, 32'h7FFF_FFFF);
      send_request(OP_INSERT, 32'h8000_0000);
      send_request(OP_INSERT, 32'h0000_0000);
      send_request(OP_INSERT, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h0001_0000);
      send_request(OP_INSERT, 32'h0000_0000);
      send_request(OP_SEARCH, 32'hFFFF_FFFF);
      send_request(OP_SEARCH, 32'h1234_5678);
      send_request(OP_SHOW,   32'hDEAD_BEEF);
      send_request(OP_REMOVE, 32'h8000_0000);
      send_request(OP_REMOVE, 32'h7FFF_FFFF);
      send_request(OP_REMOVE, 32'h7FFF_FFFF);
      send_request(OP_SHOW,   32'h0000_0000);
      // zero capacity refuses inserts; duplicate test comes first
      wait_idle();
      write_capacity(6'd0);
      send_request(OP_INSERT, 32'h5555_5555);
      send_request(OP_INSERT, 32'h0000_0000);
      wait_idle();
      write_capacity(6'd3);
      send_request(OP_INSERT, 32'hAAAA_AAAA);
      // capacity below count
      wait_idle();
      write_capacity(6'd2);
      send_request(OP_INSERT, 32'h0000_002A);
      send_request(OP_REMOVE, 32'h0000_0000);
      send_request(OP_INSERT, 32'h0000_002A);
      // out-of-range capacity clamps to depth
      wait_idle();
      write_capacity(6'd63);
      send_request(OP_INSERT, 32'h0000_002A);
      send_request(OP_SHOW,   32'h0000_0000);

      run_phase(6'd32, 0,  0,  70, 45);
      run_phase(6'd32, 59, 0,  70, 70);
      run_phase(6'd5,  0,  59, 70, 40);
      run_phase(6'd1,  35, 35, 70, 40);
      run_phase(6'd63, 0,  0,  70, 70);
      run_phase(6'd16, 35, 35, 70, 15);

      wait_idle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
